// ----- hw/rtl/ibl_pkg.sv -----
// ibl_pkg: shared types and codes for the ipv4 blocklist table
// request/response words, queued job format, front/back control structs
// no dependencies
`timescale 1ns / 1ps

package ibl_pkg;

   // request kinds
   localparam logic [1:0] REQ_LOOKUP = 2'd0;
   localparam logic [1:0] REQ_ADD    = 2'd1;
   localparam logic [1:0] REQ_DELETE = 2'd2;
   localparam logic [1:0] REQ_CLEAR  = 2'd3;

   // response status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EXISTS    = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] addr;
   } req_word_type;

   typedef struct packed {
      logic [1:0] status;
      logic       drop;
   } rsp_word_type;

   // classified request as held in the queue
   typedef struct packed {
      logic        scan;   // needs a table scan (lookup, add, delete)
      logic [1:0]  kind;
      logic [31:0] addr;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } fe_out_type;

   typedef struct packed {
      logic take;   // back end pops the queue head
      logic busy;   // clearing pass after reset in progress
   } be_ctl_type;

endpackage

// ----- hw/rtl/ipv4_blocklist_table.sv -----
// ipv4_blocklist_table: top level of the blocked-address table
// depends on ibl_pkg, ibl_front, ibl_engine
`timescale 1ns / 1ps
//
// usage
//   req channel: one word per request, req_word.req_type selects lookup, add,
//     delete or clear, req_word.addr carries the ipv4 address
//   rsp channel: exactly one word per request, in request order; status is
//     ok / already present / not found / table full, drop flags a lookup hit
//   both channels: word moves when valid is high and stall is low
// timing
//   lookup, add and delete scan the table memory one entry per cycle,
//     set by the single read port of the table memory
//   clear sweeps the valid marks one entry per cycle
//   a two-word queue in front takes requests while the engine works
// reset
//   reset starts a clearing pass over every entry; req_stall stays high
//   until it is over, rsp_valid is low
// stall
//   a stalled response holds in the output register; the engine finishes
//   the next word and then waits, the queue fills and req_stall rises
//

module ipv4_blocklist_table
   import ibl_pkg::*;
#(
   parameter int ENTRIES = 64
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   fe_out_type fe_out;
   be_ctl_type be_ctl;

   // front: accept and classify, hold up to two words
   ibl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .fe_out    (fe_out),
      .be_ctl    (be_ctl)
   );

   // back: table scan, write-back and response register
   ibl_engine #(
      .ENTRIES (ENTRIES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .fe_out    (fe_out),
      .be_ctl    (be_ctl),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

// ----- hw/rtl/ibl_front.sv -----
// ibl_front: request intake, classification and two-word job queue
// depends on ibl_pkg
`timescale 1ns / 1ps

module ibl_front
   import ibl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output fe_out_type   fe_out,
   input  be_ctl_type   be_ctl
);

   job_type    q_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       push;
   logic       pop;
   job_type    job_new;

   assign req_stall = (count_ff == 2'd2) || be_ctl.busy;
   assign push      = req_valid && !req_stall;
   assign pop       = be_ctl.take && (count_ff != 2'd0);

   assign job_new.scan = (req_word.req_type != REQ_CLEAR);
   assign job_new.kind = req_word.req_type;
   assign job_new.addr = req_word.addr;

   assign fe_out.valid = (count_ff != 2'd0);
   assign fe_out.job   = q_ff[rd_ptr_ff];

   always_comb begin
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= job_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

endmodule

// ----- hw/rtl/ibl_engine.sv -----
// ibl_engine: table memory, scan sequencer, write-back and response register
// depends on ibl_pkg
`timescale 1ns / 1ps

module ibl_engine
   import ibl_pkg::*;
#(
   parameter int ENTRIES = 64
)
(
   input  logic         clock,
   input  logic         reset,
   input  fe_out_type   fe_out,
   output be_ctl_type   be_ctl,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

   typedef enum logic [2:0] {
      S_SWEEP,
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   // entry: valid mark on top of the address
   logic [32:0] mem [ENTRIES];
   logic [32:0] rd_data_ff;

   state_type    state_ff;
   logic [IW-1:0] idx_ff;
   logic          issue_done_ff;
   logic          cmp_valid_ff;
   logic [IW-1:0] cmp_idx_ff;
   job_type       job_ff;
   logic          hit_ff;
   logic [IW-1:0] hit_idx_ff;
   logic          free_ff;
   logic [IW-1:0] free_idx_ff;
   logic          sweep_rsp_ff;
   logic          init_ff;
   logic          rsp_valid_ff;
   rsp_word_type  rsp_word_ff;

   logic          out_free;
   logic          need_write;
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   logic [32:0]   mem_wdata;
   logic          cmp_hit;
   logic          cmp_free;
   rsp_word_type  result;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign be_ctl.take = (state_ff == S_IDLE) && fe_out.valid;
   assign be_ctl.busy = init_ff;

   assign cmp_hit  = cmp_valid_ff && rd_data_ff[32] && (rd_data_ff[31:0] == job_ff.addr);
   assign cmp_free = cmp_valid_ff && !rd_data_ff[32];

   always_comb begin
      need_write = 1'b0;
      result     = '{status: ST_OK, drop: 1'b0};
      case (job_ff.kind)
         REQ_LOOKUP: begin
            result.drop = hit_ff;
         end
         REQ_ADD: begin
            if (hit_ff) begin
               result.status = ST_EXISTS;
            end else if (!free_ff) begin
               result.status = ST_FULL;
            end else begin
               need_write = 1'b1;
            end
         end
         REQ_DELETE: begin
            if (hit_ff) begin
               need_write = 1'b1;
            end else begin
               result.status = ST_NOT_FOUND;
            end
         end
         default: begin
            result.status = ST_OK;
         end
      endcase
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = {1'b0, job_ff.addr};
      if (state_ff == S_SWEEP) begin
         mem_we = 1'b1;
      end else if (state_ff == S_FINISH && out_free && need_write) begin
         mem_we    = 1'b1;
         mem_waddr = (job_ff.kind == REQ_ADD) ? free_idx_ff : hit_idx_ff;
         mem_wdata = {(job_ff.kind == REQ_ADD), job_ff.addr};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         idx_ff        <= '0;
         issue_done_ff <= 1'b0;
         cmp_valid_ff  <= 1'b0;
         sweep_rsp_ff  <= 1'b0;
         init_ff       <= 1'b1;
         rsp_valid_ff  <= 1'b0;
         hit_ff        <= 1'b0;
         free_ff       <= 1'b0;
      end else begin
         // in finish the response register is reloaded instead
         if (rsp_valid_ff && !rsp_stall && state_ff != S_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         cmp_valid_ff <= (state_ff == S_SCAN) && !issue_done_ff;
         cmp_idx_ff   <= idx_ff;
         case (state_ff)
            S_SWEEP: begin
               if (idx_ff == LAST) begin
                  init_ff <= 1'b0;
                  state_ff <= sweep_rsp_ff ? S_FINISH : S_IDLE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (fe_out.valid) begin
                  job_ff        <= fe_out.job;
                  idx_ff        <= '0;
                  issue_done_ff <= 1'b0;
                  hit_ff        <= 1'b0;
                  free_ff       <= 1'b0;
                  sweep_rsp_ff  <= 1'b1;
                  state_ff      <= fe_out.job.scan ? S_SCAN : S_SWEEP;
               end
            end
            S_SCAN: begin
               if (!issue_done_ff) begin
                  if (idx_ff == LAST) begin
                     issue_done_ff <= 1'b1;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
               if (cmp_hit && !hit_ff) begin
                  hit_ff     <= 1'b1;
                  hit_idx_ff <= cmp_idx_ff;
               end
               if (cmp_free && !free_ff) begin
                  free_ff     <= 1'b1;
                  free_idx_ff <= cmp_idx_ff;
               end
               if (cmp_valid_ff && cmp_idx_ff == LAST) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_word_ff  <= result;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ----- hw/rtl/ibl_checker.sv -----
// ibl_checker: port-level checks for ipv4_blocklist_table, bound to the top
// depends on ibl_pkg
`timescale 1ns / 1ps

module ibl_checker
   import ibl_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_word_type req_word,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   // a stalled request word holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_word))
      else $error("request word changed while stalled");

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   // drop only comes with an ok status
   a_drop_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.drop |-> rsp_word.status == ST_OK)
      else $error("drop with non-ok status");

   // clearing pass after reset keeps intake closed
   a_init_stall: assert property (@(posedge clock)
      !reset && $past(reset) |-> req_stall)
      else $error("request taken during clearing pass");

   // no response right out of reset
   a_init_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response right after reset");

endmodule

bind ipv4_blocklist_table ibl_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

// ----- sim/ibl_table_checker.sv -----
// ibl_table_checker: response checker for the ipv4 blocklist table
// watches the req and rsp channels, predicts each response word, compares
// depends on ibl_pkg
`timescale 1ns / 1ps

module ibl_table_checker
   import ibl_pkg::*;
#(
   parameter int ENTRIES = 64
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_word_type rsp_word,
   output int           error_count,
   output int           pending_count
);

   logic [31:0]  shadow_addr [ENTRIES];
   logic         shadow_live [ENTRIES];
   rsp_word_type expected_q [$];

   // applies one request to the shadow table, returns the response it earns
   function automatic rsp_word_type apply_request(input req_word_type w);
      rsp_word_type r;
      int           hit;
      int           free;
      r.status = ST_OK;
      r.drop   = 1'b0;
      hit      = -1;
      free     = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit < 0 && shadow_live[i] && shadow_addr[i] == w.addr) hit = i;
         if (free < 0 && !shadow_live[i]) free = i;
      end
      case (w.req_type)
         REQ_LOOKUP: begin
            r.drop = (hit >= 0);
         end
         REQ_ADD: begin
            if (hit >= 0) begin
               r.status = ST_EXISTS;
            end else if (free < 0) begin
               r.status = ST_FULL;
            end else begin
               shadow_addr[free] = w.addr;
               shadow_live[free] = 1'b1;
            end
         end
         REQ_DELETE: begin
            if (hit < 0) r.status = ST_NOT_FOUND;
            else shadow_live[hit] = 1'b0;
         end
         default: begin
            for (int i = 0; i < ENTRIES; i++) shadow_live[i] = 1'b0;
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) shadow_live[i] = 1'b0;
         expected_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("unexpected rsp word: status %0d drop %0d",
                      rsp_word.status, rsp_word.drop);
               error_count++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_word.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_word.status);
                  error_count++;
               end
               if (rsp_word.drop !== want.drop) begin
                  $error("drop: expected %0d, actual %0d", want.drop, rsp_word.drop);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) expected_q.push_back(apply_request(req_word));
      end
      pending_count = expected_q.size();
   end

endmodule

// ----- sim/tb_ipv4_blocklist_table.sv -----
// tb_ipv4_blocklist_table: stimulus and verdict for the ipv4 blocklist table
// depends on ibl_pkg, ipv4_blocklist_table and ibl_table_checker
`timescale 1ns / 1ps

module tb_ipv4_blocklist_table;
   import ibl_pkg::*;

   localparam int ENTRIES      = 64;
   localparam int POOL_SIZE    = 96;     // more than ENTRIES so fill runs overflow
   localparam int TOTAL_WORDS  = 625;    // directed part plus about 600 random words
   localparam int LONG_HOLD    = 600;    // receiver hold-off, cycles
   localparam int DRAIN_CYCLES = 200;    // idle slack at the end, after the final drain
   localparam int CYCLE_LIMIT  = 400000; // ~700 words at their worst case, many times over

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   int error_count;
   int pending_count;
   int cycle_count;
   int words_sent;

   // idling knobs set by the stimulus, read by the sender and the receiver
   bit send_quiet;
   bit rsp_quiet;
   int long_holds_asked;   // long receiver hold-offs requested so far

   // addresses reused often enough to hit, all distinct by their low bits
   logic [31:0] addr_pool [POOL_SIZE];

   ipv4_blocklist_table #(.ENTRIES(ENTRIES)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   ibl_table_checker #(.ENTRIES(ENTRIES)) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_word      (rsp_word),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // 20 ns clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // watchdog, covers the clearing pass after reset as well
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_ipv4_blocklist_table: done, errors");
         $finish;
      end
   end

   // response side: random hold-off before each word, a quiet mode with none,
   // and one long hold-off on request that backs the table up into req_stall
   initial begin
      int gap;
      int long_holds_done;
      rsp_stall       = 1'b0;
      long_holds_done = 0;
      forever begin
         if (long_holds_done != long_holds_asked) begin
            gap = LONG_HOLD;
            long_holds_done++;
         end else if (rsp_quiet) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 15);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         // stall is low from here on, so the next valid edge takes the word
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // offer one request word, return at the edge that takes it
   // valid stays high afterwards, the next call or a drain decides
   task automatic send_word(input logic [1:0] kind, input logic [31:0] address);
      int           gap;
      req_word_type w;
      gap = send_quiet ? 0 : $urandom_range(0, 15);
      w.req_type = kind;
      w.addr     = address;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // stop offering and wait for every outstanding response word
   // polled at the falling edge so the checker's update has settled
   task automatic drain_all();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   // mostly pool addresses so lookups and deletes hit, some fully random
   function automatic logic [31:0] pick_addr();
      if ($urandom_range(0, 99) < 85) return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   // empty the table, then add distinct addresses past its capacity
   task automatic fill_run();
      int start;
      start = $urandom_range(0, POOL_SIZE - 1);
      send_word(REQ_CLEAR, $urandom);
      for (int k = 0; k < ENTRIES + 8; k++) begin
         if ($urandom_range(0, 6) == 0) send_word(REQ_LOOKUP, pick_addr());
         send_word(REQ_ADD, addr_pool[(start + k) % POOL_SIZE]);
      end
      // table is full: a present address still reports already present
      send_word(REQ_ADD, addr_pool[start]);
      send_word(REQ_LOOKUP, addr_pool[(start + ENTRIES - 1) % POOL_SIZE]);
      // free one slot mid-table, refill it, then overflow again
      send_word(REQ_DELETE, addr_pool[(start + 5) % POOL_SIZE]);
      send_word(REQ_ADD, $urandom);
      send_word(REQ_ADD, $urandom);
   endtask

   // mixed traffic, clears rare enough that the table gets well populated
   task automatic mixed_run(input int count);
      int pick;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 2) send_word(REQ_CLEAR, $urandom);
         else if (pick < 37) send_word(REQ_ADD, pick_addr());
         else if (pick < 67) send_word(REQ_DELETE, pick_addr());
         else if (pick < 97) send_word(REQ_LOOKUP, pick_addr());
         else send_word(2'($urandom_range(0, 3)), $urandom);
      end
   endtask

   initial begin
      int episode;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_word         = '0;
      words_sent       = 0;
      send_quiet       = 1'b0;
      rsp_quiet        = 1'b0;
      long_holds_asked = 0;
      episode          = 0;

      addr_pool[0] = 32'h0000_0000;
      for (int i = 1; i < POOL_SIZE; i++) addr_pool[i] = ($urandom & 32'hFFFF_FF80) | i;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, extreme addresses, every request kind
      send_word(REQ_LOOKUP, 32'h0000_0000);
      send_word(REQ_LOOKUP, 32'hFFFF_FFFF);
      send_word(REQ_ADD,    32'h0000_0000);   // address zero is an ordinary entry
      send_word(REQ_ADD,    32'hFFFF_FFFF);
      send_word(REQ_ADD,    32'h0000_0000);   // duplicate add
      send_word(REQ_LOOKUP, 32'h0000_0000);
      send_word(REQ_LOOKUP, 32'hFFFF_FFFF);
      send_word(REQ_LOOKUP, 32'h0000_0001);   // near miss
      send_word(REQ_DELETE, 32'h0000_0001);   // delete miss
      send_word(REQ_DELETE, 32'h0000_0000);
      send_word(REQ_LOOKUP, 32'h0000_0000);
      send_word(REQ_DELETE, 32'h0000_0000);   // already gone
      send_word(REQ_ADD,    32'h0000_0000);   // reuses the lowest free slot
      send_word(REQ_ADD,    32'hA5A5_A5A5);
      send_word(REQ_ADD,    32'h5A5A_5A5A);
      send_word(REQ_LOOKUP, 32'h5A5A_5A5A);
      send_word(REQ_CLEAR,  32'hFFFF_FFFF);
      send_word(REQ_LOOKUP, 32'hFFFF_FFFF);
      send_word(REQ_CLEAR,  32'h0000_0000);   // clear on an empty table
      send_word(REQ_DELETE, 32'hFFFF_FFFF);
      send_word(REQ_ADD,    32'h8000_0000);
      send_word(REQ_LOOKUP, 32'h7FFF_FFFF);
      send_word(REQ_LOOKUP, 32'h8000_0000);
      drain_all();

      // random episodes: every third a fill run, the rest mixed traffic
      while (words_sent < TOTAL_WORDS) begin
         send_quiet = ($urandom_range(0, 3) == 0);
         rsp_quiet  = ($urandom_range(0, 3) == 0);
         if (episode == 2) begin
            // back-pressure: sender keeps offering while the receiver holds off
            send_quiet = 1'b1;
            rsp_quiet  = 1'b0;
            long_holds_asked++;
         end
         if (episode % 3 == 1) begin
            fill_run();
            drain_all();   // sender pauses until every response is in
         end else begin
            mixed_run($urandom_range(40, 100));
         end
         episode++;
      end

      drain_all();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_ipv4_blocklist_table: done, clean");
      end else begin
         $display("tb_ipv4_blocklist_table: done, errors");
      end
      $finish;
   end

endmodule
